>>> src/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared types, constants and a helper function for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int QP_W    = 14;   // q and p in units of 1/10000, max 10000
    localparam int WGT_W   = 6;    // segment weight, 0..60
    localparam int NUM_W   = 20;   // channel numerator over 600000, max 600000
    localparam int SCL_W   = 24;   // 17 * num + bias
    localparam int QUO_W   = 18;   // scaled value after the shift by 6 (divide by 64)
    localparam int RCP_W   = 17;   // reciprocal constant width
    localparam int PROD_W  = QUO_W + RCP_W;
    localparam int REM_W   = 11;

    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_THIRD = 9'd120;
    localparam logic [HUE_W-1:0] HUE_2THRD = 9'd240;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;

    // round(255 * num / 600000) == (17 * num + 20000) / 40000
    // and 40000 = 64 * 625; the /625 goes through a reciprocal multiply.
    localparam logic [4:0]        RND_MUL    = 5'd17;
    localparam logic [SCL_W-1:0]  RND_BIAS   = 24'd20000;
    localparam int                RND_SHIFT  = 6;
    localparam logic [RCP_W-1:0]  RCP_K      = 17'd107374;  // floor(2^26 / 625)
    localparam int                RCP_SHIFT  = 26;
    localparam logic [QUO_W-1:0]  DIV_Q      = 18'd625;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // Stage load strobes for the per-channel datapath.
    typedef struct packed {
        logic ld_mul;
        logic ld_scl;
        logic ld_rcp;
        logic ld_out;
    } chan_ctl_t;

    // Weight on (q - p) for a shifted hue t in 0..360.
    function automatic logic [WGT_W-1:0] seg_weight(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] w;
        begin
            if (t < 9'd60) begin
                w = t;
            end else if (t < 9'd180) begin
                w = 9'd60;
            end else if (t < HUE_2THRD) begin
                w = HUE_2THRD - t;
            end else begin
                w = 9'd0;
            end
            seg_weight = w[WGT_W-1:0];
        end
    endfunction

endpackage

>>> src/hsl2rgb_channel.sv
// ----------------------------------------------------------------------------
// hsl2rgb_channel
// One color channel: segment numerator, scaling and rounded divide to 8 bits.
// ----------------------------------------------------------------------------
module hsl2rgb_channel (
    input  logic                                   aclk,
    input  hsl2rgb_pkg::chan_ctl_t                 ctl,
    input  logic [hsl2rgb_pkg::QP_W-1:0]           p,
    input  logic [hsl2rgb_pkg::QP_W-1:0]           q,
    input  logic [hsl2rgb_pkg::WGT_W-1:0]          wgt,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]         color
);

    logic [hsl2rgb_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [hsl2rgb_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [hsl2rgb_pkg::QUO_W-1:0]   quo_d_reg;
    logic [hsl2rgb_pkg::CHAN_W-1:0]  est_reg, est_next;
    logic [hsl2rgb_pkg::CHAN_W-1:0]  color_reg, color_next;

    logic [hsl2rgb_pkg::QP_W-1:0]    diff;
    logic [hsl2rgb_pkg::SCL_W-1:0]   scaled;
    logic [hsl2rgb_pkg::PROD_W-1:0]  prod;
    logic [hsl2rgb_pkg::QUO_W-1:0]   back;
    logic [hsl2rgb_pkg::REM_W-1:0]   rem;

    // num = 60 p + (q - p) * w
    always_comb begin
        diff     = q - p;
        num_next = hsl2rgb_pkg::NUM_W'(p * 20'd60)
                 + hsl2rgb_pkg::NUM_W'(diff) * hsl2rgb_pkg::NUM_W'(wgt);
    end

    always_comb begin
        scaled   = hsl2rgb_pkg::SCL_W'(num_reg) * hsl2rgb_pkg::SCL_W'(hsl2rgb_pkg::RND_MUL)
                 + hsl2rgb_pkg::RND_BIAS;
        quo_next = scaled[hsl2rgb_pkg::SCL_W-1:hsl2rgb_pkg::RND_SHIFT];
    end

    // estimate is the true quotient or one below
    always_comb begin
        prod     = hsl2rgb_pkg::PROD_W'(quo_reg) * hsl2rgb_pkg::PROD_W'(hsl2rgb_pkg::RCP_K);
        est_next = prod[hsl2rgb_pkg::RCP_SHIFT+hsl2rgb_pkg::CHAN_W-1:hsl2rgb_pkg::RCP_SHIFT];
    end

    always_comb begin
        back = hsl2rgb_pkg::QUO_W'(est_reg * hsl2rgb_pkg::DIV_Q);
        rem  = hsl2rgb_pkg::REM_W'(quo_d_reg - back);
        if (rem >= hsl2rgb_pkg::REM_W'(hsl2rgb_pkg::DIV_Q)) begin
            color_next = est_reg + 8'd1;
        end else begin
            color_next = est_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_mul) begin
            num_reg <= num_next;
        end
        if (ctl.ld_scl) begin
            quo_reg <= quo_next;
        end
        if (ctl.ld_rcp) begin
            est_reg   <= est_next;
            quo_d_reg <= quo_reg;
        end
        if (ctl.ld_out) begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

>>> src/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Six-stage pipelined HSL to 8-bit RGB converter with exact integer rounding.
// ----------------------------------------------------------------------------
//  channel   direction  payload                          handshake
//  s_        in         hsl_t {hue_deg, saturation,      s_valid / s_ready
//                              lightness}
//  m_        out        rgb_t {red, green, blue}         m_valid / m_ready
//
//  One transaction per clock sustained while m_ready is high; an input passes
//  through the six register stages (clamp/hue wrap, q/p multiply, segment
//  multiply, scale, reciprocal multiply, correction) to m_valid.
//  aresetn (synchronous, active low) clears all stage valid bits only.
//  A stall at m_ready holds the output stage; bubbles upstream still collapse,
//  so s_ready drops only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hsl2rgb_pkg::hsl_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hsl2rgb_pkg::rgb_t   m_data
);

    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Stage control: valid bit per stage, load when the stage is free or
    // its contents move on this cycle, and valid data waits before it.
    // ------------------------------------------------------------------
    logic [NSTG:1] vld_reg, vld_next;
    logic [NSTG:1] adv;
    logic [NSTG:1] load;
    logic [NSTG:0] vin;

    always_comb begin
        adv[NSTG] = !vld_reg[NSTG] || m_ready;
        for (int i = NSTG - 1; i >= 1; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        vin = {vld_reg, s_valid};
        for (int i = 1; i <= NSTG; i++) begin
            load[i]     = adv[i] && vin[i-1];
            vld_next[i] = adv[i] ? vin[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[1];
    assign m_valid = vld_reg[NSTG];

    // ------------------------------------------------------------------
    // Stage 1: clamp percentages, wrap hue, form the three shifted hues.
    // A shifted hue of exactly 360 is kept (weight zero, same as 0).
    // ------------------------------------------------------------------
    logic [hsl2rgb_pkg::PCT_W-1:0] sat_reg, sat_next;
    logic [hsl2rgb_pkg::PCT_W-1:0] lgt_reg, lgt_next;
    logic [hsl2rgb_pkg::HUE_W-1:0] tr_reg, tr_next;
    logic [hsl2rgb_pkg::HUE_W-1:0] tg_reg, tg_next;
    logic [hsl2rgb_pkg::HUE_W-1:0] tb_reg, tb_next;
    logic [hsl2rgb_pkg::HUE_W:0]   hr_sum;

    always_comb begin
        sat_next = (s_data.saturation > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX
                                                              : s_data.saturation;
        lgt_next = (s_data.lightness > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX
                                                             : s_data.lightness;
        if (s_data.hue_deg >= hsl2rgb_pkg::HUE_FULL) begin
            tg_next = s_data.hue_deg - hsl2rgb_pkg::HUE_FULL;
        end else begin
            tg_next = s_data.hue_deg;
        end
        hr_sum = {1'b0, tg_next} + {1'b0, hsl2rgb_pkg::HUE_THIRD};
        if (hr_sum > {1'b0, hsl2rgb_pkg::HUE_FULL}) begin
            tr_next = hsl2rgb_pkg::HUE_W'(hr_sum - {1'b0, hsl2rgb_pkg::HUE_FULL});
        end else begin
            tr_next = hsl2rgb_pkg::HUE_W'(hr_sum);
        end
        if (tg_next < hsl2rgb_pkg::HUE_THIRD) begin
            tb_next = tg_next + hsl2rgb_pkg::HUE_2THRD;
        end else begin
            tb_next = tg_next - hsl2rgb_pkg::HUE_THIRD;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: q and p (units of 1/10000) and per-channel segment weight.
    // Zero saturation gives q == p == 100 l, so grey needs no special path.
    // ------------------------------------------------------------------
    logic [hsl2rgb_pkg::QP_W-1:0]  q_reg, q_next;
    logic [hsl2rgb_pkg::QP_W-1:0]  p_reg, p_next;
    logic [hsl2rgb_pkg::WGT_W-1:0] wr_reg, wg_reg, wb_reg;
    logic [hsl2rgb_pkg::QP_W-1:0]  ls;
    logic [hsl2rgb_pkg::QP_W-1:0]  l100;
    logic [hsl2rgb_pkg::QP_W-1:0]  s100;

    always_comb begin
        ls   = hsl2rgb_pkg::QP_W'(lgt_reg) * hsl2rgb_pkg::QP_W'(sat_reg);
        l100 = hsl2rgb_pkg::QP_W'(lgt_reg * 14'd100);
        s100 = hsl2rgb_pkg::QP_W'(sat_reg * 14'd100);
        if (lgt_reg < hsl2rgb_pkg::PCT_HALF) begin
            q_next = l100 + ls;
        end else begin
            q_next = l100 + s100 - ls;
        end
        p_next = l100 + l100 - q_next;
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            sat_reg <= sat_next;
            lgt_reg <= lgt_next;
            tr_reg  <= tr_next;
            tg_reg  <= tg_next;
            tb_reg  <= tb_next;
        end
        if (load[2]) begin
            q_reg  <= q_next;
            p_reg  <= p_next;
            wr_reg <= hsl2rgb_pkg::seg_weight(tr_reg);
            wg_reg <= hsl2rgb_pkg::seg_weight(tg_reg);
            wb_reg <= hsl2rgb_pkg::seg_weight(tb_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..6: per-channel numerator, scale, divide and round.
    // ------------------------------------------------------------------
    hsl2rgb_pkg::chan_ctl_t ctl;

    assign ctl.ld_mul = load[3];
    assign ctl.ld_scl = load[4];
    assign ctl.ld_rcp = load[5];
    assign ctl.ld_out = load[6];

    hsl2rgb_channel u_red (
        .aclk  (aclk),
        .ctl   (ctl),
        .p     (p_reg),
        .q     (q_reg),
        .wgt   (wr_reg),
        .color (m_data.red)
    );

    hsl2rgb_channel u_green (
        .aclk  (aclk),
        .ctl   (ctl),
        .p     (p_reg),
        .q     (q_reg),
        .wgt   (wg_reg),
        .color (m_data.green)
    );

    hsl2rgb_channel u_blue (
        .aclk  (aclk),
        .ctl   (ctl),
        .p     (p_reg),
        .q     (q_reg),
        .wgt   (wb_reg),
        .color (m_data.blue)
    );

`ifndef SYNTHESIS
    // full pipeline with a stalled output must refuse new input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

    // a transaction leaving stage 5 shows up at the output next cycle
    a_last_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTG-1] && adv[NSTG]) |=> m_valid)
        else $error("transaction lost between stage 5 and output");

    // q/p bounds keep every numerator within 600000
    a_qp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> (q_reg >= p_reg && q_reg <= 14'd10000))
        else $error("q/p out of range");

    // reset empties the output stage
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule
